/* sv/hmq_pkg.sv */
// ----------------------------------------------------------------------------
// hmq_pkg
// Shared types and constants of the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package hmq_pkg;

    localparam int KEY_W    = 31;
    localparam int TAG_W    = 16;
    localparam int OCC_W    = 7;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 13;
    localparam int LVL_W    = 4;

    localparam logic MODE_INSERT  = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INACTIVE = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [LVL_W-1:0] lvl;
        logic [IDX_W-1:0] idx;
        t_entry           ent;
    } t_cell_wr;

    typedef struct packed {
        logic [LVL_W-1:0] lvl;
        logic [IDX_W-1:0] idx_a;
        logic [IDX_W-1:0] idx_b;
    } t_cell_rd;

endpackage

/* sv/hmq_in_if.sv */
// ----------------------------------------------------------------------------
// hmq_in_if
// Request channel: insert or extract-min beats.
// ----------------------------------------------------------------------------
interface hmq_in_if;

    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [hmq_pkg::KEY_W-1:0]  job_key;
    logic [hmq_pkg::TAG_W-1:0]  job_tag;

    modport source (output valid, mode, job_key, job_tag, input ready);
    modport sink   (input valid, mode, job_key, job_tag, output ready);

endinterface

/* sv/hmq_out_if.sv */
// ----------------------------------------------------------------------------
// hmq_out_if
// Response channel: one beat per request.
// ----------------------------------------------------------------------------
interface hmq_out_if;

    logic                          valid;
    logic                          ready;
    logic [hmq_pkg::STATUS_W-1:0]  status;
    logic [hmq_pkg::KEY_W-1:0]     out_key;
    logic [hmq_pkg::TAG_W-1:0]     out_tag;
    logic [hmq_pkg::OCC_W-1:0]     occupancy;

    modport source (output valid, status, out_key, out_tag, occupancy, input ready);
    modport sink   (input valid, status, out_key, out_tag, occupancy, output ready);

endinterface

/* sv/hmq_cell.sv */
// ----------------------------------------------------------------------------
// hmq_cell
// One heap level: entry storage with one write and two registered reads,
// merged onto the read chain toward the root.
// ----------------------------------------------------------------------------
module hmq_cell #(
    parameter int LEVEL      = 0,
    parameter int CELL_DEPTH = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hmq_pkg::t_cell_wr i_wr,
    input  hmq_pkg::t_cell_rd i_rd,
    input  hmq_pkg::t_entry   i_chain_a,
    input  hmq_pkg::t_entry   i_chain_b,
    output hmq_pkg::t_entry   o_chain_a,
    output hmq_pkg::t_entry   o_chain_b
);

    localparam int AW = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
    localparam logic [hmq_pkg::IDX_W-1:0] OFF_MASK = hmq_pkg::IDX_W'((1 << LEVEL) - 1);
    localparam logic [hmq_pkg::LVL_W-1:0] MY_LVL   = hmq_pkg::LVL_W'(LEVEL);

    hmq_pkg::t_entry r_mem [CELL_DEPTH];
    hmq_pkg::t_entry r_rd_a;
    hmq_pkg::t_entry r_rd_b;
    logic            r_sel;

    logic [hmq_pkg::IDX_W-1:0] w_off_w;
    logic [hmq_pkg::IDX_W-1:0] w_off_a;
    logic [hmq_pkg::IDX_W-1:0] w_off_b;
    logic [AW-1:0]             w_addr_w;
    logic [AW-1:0]             w_addr_a;
    logic [AW-1:0]             w_addr_b;

    assign w_off_w  = i_wr.idx & OFF_MASK;
    assign w_off_a  = i_rd.idx_a & OFF_MASK;
    assign w_off_b  = i_rd.idx_b & OFF_MASK;
    assign w_addr_w = w_off_w[AW-1:0];
    assign w_addr_a = w_off_a[AW-1:0];
    assign w_addr_b = w_off_b[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.lvl == MY_LVL)) begin
            r_mem[w_addr_w] <= i_wr.ent;
        end
        r_rd_a <= r_mem[w_addr_a];
        r_rd_b <= r_mem[w_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= 1'b0;
        end else begin
            r_sel <= (i_rd.lvl == MY_LVL);
        end
    end

    assign o_chain_a = r_sel ? r_rd_a : i_chain_a;
    assign o_chain_b = r_sel ? r_rd_b : i_chain_b;

endmodule

/* sv/binary_min_heap_queue_top.sv */
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top
// Bounded binary min-heap priority queue built as a chain of level cells.
// The response beat is registered and appears in the cycle after the request is accepted.
// Requests are taken one at a time: a new one is accepted only after the last
// has sifted into place, and a refused request or the last extract needs no sift.
// A waiting response holds requests.
// Reset: synchronous active-low; queue empty, queue_active set, no clear sweep.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_top #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hmq_in_if.sink       i_req,
    hmq_out_if.source    o_rsp,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int IW = $clog2(QUEUE_DEPTH + 1);
    localparam int NL = IW;
    localparam int LW = $clog2(NL);
    localparam int XW = hmq_pkg::IDX_W;
    localparam int VW = hmq_pkg::LVL_W;
    localparam int OW = hmq_pkg::OCC_W;
    localparam logic [IW-1:0] CNT_FULL = IW'(QUEUE_DEPTH);
    localparam logic [IW-1:0] IDX_ROOT = IW'(1);
    localparam logic          REG_QUEUE_ACTIVE = 1'b0;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP_RD   = 3'd1;
    localparam logic [2:0] S_UP_CMP  = 3'd2;
    localparam logic [2:0] S_DN_LOAD = 3'd3;
    localparam logic [2:0] S_DN_RD   = 3'd4;
    localparam logic [2:0] S_DN_CMP  = 3'd5;

    logic [2:0]                   r_state, n_state;
    logic [IW-1:0]                r_count, n_count;
    logic [LW-1:0]                r_cnt_lvl, n_cnt_lvl;
    logic [IW-1:0]                r_hole, n_hole;
    logic [LW-1:0]                r_lvl, n_lvl;
    logic [IW-1:0]                r_child, n_child;
    logic                         r_has_r, n_has_r;
    logic                         r_active;
    hmq_pkg::t_entry              r_mov, n_mov;
    hmq_pkg::t_entry              r_root, n_root;
    logic                         r_out_valid, n_out_valid;
    logic [hmq_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [hmq_pkg::KEY_W-1:0]    r_out_key, n_out_key;
    logic [hmq_pkg::TAG_W-1:0]    r_out_tag, n_out_tag;
    logic [OW-1:0]                r_out_occ, n_out_occ;

    hmq_pkg::t_cell_wr w_wr;
    hmq_pkg::t_cell_rd w_rd;
    hmq_pkg::t_entry   w_chain_a [NL+1];
    hmq_pkg::t_entry   w_chain_b [NL+1];
    hmq_pkg::t_entry   w_a;
    hmq_pkg::t_entry   w_b;

    logic            w_acc;
    logic            w_cfg_wr;
    logic [IW-1:0]   w_cnt_inc;
    logic [IW-1:0]   w_cnt_dec;
    logic            w_inc_pow2;
    logic            w_dec_pow2;
    logic [IW:0]     w_child;
    logic [IW:0]     w_child_r;
    logic            w_has_l;
    logic            w_has_r;
    logic            w_left_lt;
    logic            w_right_lt;
    logic [hmq_pkg::KEY_W-1:0] w_best_key;

    assign w_chain_a[NL] = '0;
    assign w_chain_b[NL] = '0;
    assign w_a = w_chain_a[0];
    assign w_b = w_chain_b[0];

    for (genvar l = 0; l < NL; l++) begin : g_cell
        localparam int CD = (((2 ** (l + 1)) - 1) <= QUEUE_DEPTH) ? (2 ** l)
                                                                   : (QUEUE_DEPTH - (2 ** l) + 1);
        hmq_cell #(
            .LEVEL      (l),
            .CELL_DEPTH (CD)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr      (w_wr),
            .i_rd      (w_rd),
            .i_chain_a (w_chain_a[l+1]),
            .i_chain_b (w_chain_b[l+1]),
            .o_chain_a (w_chain_a[l]),
            .o_chain_b (w_chain_b[l])
        );
    end

    assign i_req.ready     = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_acc           = i_req.valid && i_req.ready;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.out_key   = r_out_key;
    assign o_rsp.out_tag   = r_out_tag;
    assign o_rsp.occupancy = r_out_occ;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_QUEUE_ACTIVE);
    assign prdata   = (paddr[2] == REG_QUEUE_ACTIVE) ? {31'd0, r_active} : 32'd0;

    assign w_cnt_inc  = r_count + IW'(1);
    assign w_cnt_dec  = r_count - IW'(1);
    assign w_inc_pow2 = ((w_cnt_inc & r_count) == '0);
    assign w_dec_pow2 = ((r_count & w_cnt_dec) == '0);

    assign w_child    = {r_hole, 1'b0};
    assign w_child_r  = {r_hole, 1'b1};
    assign w_has_l    = (w_child <= {1'b0, r_count});
    assign w_has_r    = (w_child_r <= {1'b0, r_count});

    assign w_left_lt  = (w_a.key < r_mov.key);
    assign w_best_key = w_left_lt ? w_a.key : r_mov.key;
    assign w_right_lt = r_has_r && (w_b.key < w_best_key);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_cnt_lvl    = r_cnt_lvl;
        n_hole       = r_hole;
        n_lvl        = r_lvl;
        n_child      = r_child;
        n_has_r      = r_has_r;
        n_mov        = r_mov;
        n_root       = r_root;
        n_out_status = r_out_status;
        n_out_key    = r_out_key;
        n_out_tag    = r_out_tag;
        n_out_occ    = r_out_occ;
        n_out_valid  = r_out_valid;
        w_rd         = '0;
        w_wr.en      = 1'b0;
        w_wr.lvl     = VW'(r_lvl);
        w_wr.idx     = XW'(r_hole);
        w_wr.ent     = r_mov;

        if (w_acc) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_out_key    = '0;
                    n_out_tag    = '0;
                    n_out_status = hmq_pkg::ST_OK;
                    n_out_occ    = OW'(r_count);
                    if (i_req.mode == hmq_pkg::MODE_INSERT) begin
                        if (r_count == CNT_FULL) begin
                            n_out_status = hmq_pkg::ST_FULL;
                        end else begin
                            n_count   = w_cnt_inc;
                            n_cnt_lvl = (w_inc_pow2 && (r_count != '0)) ? r_cnt_lvl + LW'(1)
                                                                        : r_cnt_lvl;
                            n_hole    = w_cnt_inc;
                            n_lvl     = n_cnt_lvl;
                            n_mov     = '{key: i_req.job_key, tag: i_req.job_tag};
                            n_out_occ = OW'(w_cnt_inc);
                            n_state   = S_UP_RD;
                        end
                    end else if (!r_active) begin
                        n_out_status = hmq_pkg::ST_INACTIVE;
                    end else if (r_count == '0) begin
                        n_out_status = hmq_pkg::ST_EMPTY;
                    end else begin
                        n_out_key = r_root.key;
                        n_out_tag = r_root.tag;
                        n_count   = w_cnt_dec;
                        n_cnt_lvl = (w_dec_pow2 && (r_count != IDX_ROOT)) ? r_cnt_lvl - LW'(1)
                                                                          : r_cnt_lvl;
                        n_out_occ = OW'(w_cnt_dec);
                        if (r_count != IDX_ROOT) begin
                            w_rd.lvl   = VW'(r_cnt_lvl);
                            w_rd.idx_a = XW'(r_count);
                            n_state    = S_DN_LOAD;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_hole == IDX_ROOT) begin
                    w_wr.en = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    w_rd.lvl   = VW'(r_lvl - LW'(1));
                    w_rd.idx_a = XW'(r_hole >> 1);
                    n_state    = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                w_wr.en = 1'b1;
                if (w_a.key <= r_mov.key) begin
                    n_state = S_IDLE;
                end else begin
                    w_wr.ent = w_a;
                    n_hole   = r_hole >> 1;
                    n_lvl    = r_lvl - LW'(1);
                    n_state  = S_UP_RD;
                end
            end
            S_DN_LOAD: begin
                n_mov   = w_a;
                n_hole  = IDX_ROOT;
                n_lvl   = '0;
                n_state = S_DN_RD;
            end
            S_DN_RD: begin
                if (!w_has_l) begin
                    w_wr.en = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    w_rd.lvl   = VW'(r_lvl + LW'(1));
                    w_rd.idx_a = XW'(w_child);
                    w_rd.idx_b = XW'(w_child_r);
                    n_child    = w_child[IW-1:0];
                    n_has_r    = w_has_r;
                    n_state    = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                w_wr.en = 1'b1;
                if (w_right_lt) begin
                    w_wr.ent = w_b;
                    n_hole   = r_child | IW'(1);
                    n_lvl    = r_lvl + LW'(1);
                    n_state  = S_DN_RD;
                end else if (w_left_lt) begin
                    w_wr.ent = w_a;
                    n_hole   = r_child;
                    n_lvl    = r_lvl + LW'(1);
                    n_state  = S_DN_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_wr.en && (r_hole == IDX_ROOT)) begin
            n_root = w_wr.ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cnt_lvl   <= '0;
            r_active    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cnt_lvl   <= n_cnt_lvl;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr) begin
                r_active <= pwdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hole       <= n_hole;
        r_lvl        <= n_lvl;
        r_child      <= n_child;
        r_has_r      <= n_has_r;
        r_mov        <= n_mov;
        r_root       <= n_root;
        r_out_status <= n_out_status;
        r_out_key    <= n_out_key;
        r_out_tag    <= n_out_tag;
        r_out_occ    <= n_out_occ;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("entry count beyond queue depth");

    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_req.mode == hmq_pkg::MODE_INSERT) && (r_count != CNT_FULL))
        |=> (r_count == $past(r_count) + IW'(1)))
        else $error("accepted insert did not grow the queue");

    a_child_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DN_CMP) |-> ((r_child <= r_count) && (r_child != '0)))
        else $error("sift-down compares a child outside the heap");

endmodule

/* tb/binary_min_heap_queue_checker.sv */
// ----------------------------------------------------------------------------
// binary_min_heap_queue_checker
// Watches the request, response and register channels of the heap queue.
// Keeps its own copy of the heap and of queue_active. Predicts the response
// of every accepted request and compares each response beat, field by field,
// with the oldest prediction. Reports the failure count and the number of
// responses still outstanding.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_checker #(
    parameter int         QUEUE_DEPTH = 64,
    parameter logic [2:0] ACTIVE_ADDR = 3'd0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hmq_in_if           i_req,
    hmq_out_if          i_rsp,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_cnt,
    output int          o_pending
);
    import hmq_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key;
        logic [TAG_W-1:0]    tag;
        logic [OCC_W-1:0]    occ;
    } t_heap_rsp;

    logic [KEY_W-1:0] heap_key [QUEUE_DEPTH];
    logic [TAG_W-1:0] heap_tag [QUEUE_DEPTH];
    int unsigned      entry_cnt = 0;
    logic             queue_active = 1'b1;
    t_heap_rsp        expected_rsp_q [$];
    int               fail_cnt = 0;

    function automatic void swap_entries(input int unsigned a, input int unsigned b);
        logic [KEY_W-1:0] k;
        logic [TAG_W-1:0] t;
        k           = heap_key[a];
        t           = heap_tag[a];
        heap_key[a] = heap_key[b];
        heap_tag[a] = heap_tag[b];
        heap_key[b] = k;
        heap_tag[b] = t;
    endfunction

    function automatic t_heap_rsp predict_heap_op(input logic mode,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [TAG_W-1:0] tag);
        t_heap_rsp   rsp;
        int unsigned pos;
        int unsigned parent;
        int unsigned left;
        int unsigned right;
        int unsigned best;
        rsp        = '0;
        rsp.status = ST_OK;
        if (mode == MODE_INSERT) begin
            if (entry_cnt >= QUEUE_DEPTH) begin
                rsp.status = ST_FULL;
            end else begin
                pos           = entry_cnt;
                heap_key[pos] = key;
                heap_tag[pos] = tag;
                entry_cnt++;
                while (pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (heap_key[parent] <= heap_key[pos]) break;
                    swap_entries(parent, pos);
                    pos = parent;
                end
            end
        end else if (!queue_active) begin
            rsp.status = ST_INACTIVE;
        end else if (entry_cnt == 0) begin
            rsp.status = ST_EMPTY;
        end else begin
            rsp.key = heap_key[0];
            rsp.tag = heap_tag[0];
            entry_cnt--;
            if (entry_cnt > 0) begin
                heap_key[0] = heap_key[entry_cnt];
                heap_tag[0] = heap_tag[entry_cnt];
                pos         = 0;
                while (1) begin
                    left  = 2 * pos + 1;
                    right = left + 1;
                    best  = pos;
                    if (left < entry_cnt && heap_key[left] < heap_key[best]) best = left;
                    if (right < entry_cnt && heap_key[right] < heap_key[best]) best = right;
                    if (best == pos) break;
                    swap_entries(pos, best);
                    pos = best;
                end
            end
        end
        rsp.occ = OCC_W'(entry_cnt);
        return rsp;
    endfunction

    function automatic void check_field(input string name, input longint unsigned exp_val,
                                        input longint unsigned act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            fail_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_heap_rsp exp_rsp;
        if (!i_rst_n) begin
            entry_cnt    = 0;
            queue_active = 1'b1;
            expected_rsp_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ACTIVE_ADDR) begin
                queue_active = i_pwdata[0];
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_rsp_q.size() == 0) begin
                    $error("response beat with nothing outstanding: status 0x%0h",
                           i_rsp.status);
                    fail_cnt++;
                end else begin
                    exp_rsp = expected_rsp_q.pop_front();
                    check_field("status", exp_rsp.status, i_rsp.status);
                    check_field("out_key", exp_rsp.key, i_rsp.out_key);
                    check_field("out_tag", exp_rsp.tag, i_rsp.out_tag);
                    check_field("occupancy", exp_rsp.occ, i_rsp.occupancy);
                end
            end
            if (i_req.valid && i_req.ready) begin
                expected_rsp_q.push_back(predict_heap_op(i_req.mode, i_req.job_key,
                                                         i_req.job_tag));
            end
        end
        o_fail_cnt <= fail_cnt;
        o_pending  <= expected_rsp_q.size();
    end

endmodule

/* tb/binary_min_heap_queue_top_tb.sv */
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top_tb
// Drives the heap queue with a short directed sequence (empty, inactive,
// extreme keys and tags, equal keys) and then random phases that fill the
// queue past full, drain it past empty and run with queue_active cleared.
// Both channels idle at random; one long response stall backs up the input.
// The checker beside the block predicts and compares every response beat.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_top_tb;
    import hmq_pkg::*;

    localparam int         QUEUE_DEPTH       = 64;
    localparam logic [2:0] ADDR_QUEUE_ACTIVE = 3'd0;
    localparam int         RANDOM_ITEMS      = 2000;
    localparam int         LONG_HOLD         = 400;
    localparam int         DRAIN_CYCLES      = 20;
    localparam int         SIFT_CYCLES       = 2 * $clog2(QUEUE_DEPTH + 1) + 2;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} t_phase_kind;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hmq_in_if  req_if ();
    hmq_out_if rsp_if ();

    int   fail_cnt;
    int   pending_cnt;
    logic hold_rsp_req = 1'b0;
    logic no_idle      = 1'b0;
    int   beats_sent   = 0;
    int   cfg_writes   = 0;
    int   phases_run   = 0;

    binary_min_heap_queue_top #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    binary_min_heap_queue_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ACTIVE_ADDR (ADDR_QUEUE_ACTIVE)
    ) checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .i_rsp      (rsp_if),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_pready   (pready),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 14);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return KEY_W'($urandom_range(0, 15));
        if (r == 4) return ($urandom_range(0, 1) == 1) ? '1 : '0;
        return KEY_W'($urandom);
    endfunction

    task automatic send_beat(input logic mode, input logic [KEY_W-1:0] key,
                             input logic [TAG_W-1:0] tag);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.mode    <= mode;
        req_if.job_key <= key;
        req_if.job_tag <= tag;
        do @(posedge i_clk); while (!req_if.ready);
        beats_sent++;
    endtask

    task automatic push_job(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag);
        send_beat(MODE_INSERT, key, tag);
    endtask

    task automatic pop_min();
        send_beat(MODE_EXTRACT, KEY_W'($urandom), TAG_W'($urandom));
    endtask

    task automatic write_active(input logic value);
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_cnt != 0);
        repeat (SIFT_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_QUEUE_ACTIVE;
        pwdata  <= {31'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_writes++;
    endtask

    initial begin : rsp_ready_drive
        int stall;
        int run;
        rsp_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_rsp_req) begin
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_rsp_req = 1'b0;
            end else begin
                stall = no_idle ? 0 : pick_gap();
                if (stall > 0) begin
                    rsp_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            rsp_if.ready <= 1'b1;
            run = $urandom_range(1, 6);
            repeat (run) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        t_phase_kind kind;
        int          phase_len;
        int          insert_pct;
        int          target;
        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.mode    <= MODE_INSERT;
        req_if.job_key <= '0;
        req_if.job_tag <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty, inactive, extremes, equal keys
        pop_min();
        write_active(1'b0);
        pop_min();
        push_job('1, '1);
        push_job('0, '0);
        pop_min();
        write_active(1'b1);
        pop_min();
        pop_min();
        pop_min();
        for (int i = 1; i <= 5; i++) push_job(KEY_W'(9), TAG_W'(i));
        push_job(KEY_W'(7), 16'hAAAA);
        push_job(KEY_W'(6), 16'h5555);
        push_job(31'h5555_5555, 16'h00FF);
        for (int i = 0; i < 9; i++) pop_min();

        target = beats_sent + RANDOM_ITEMS;
        while (beats_sent < target) begin
            kind = t_phase_kind'(phases_run % 3);
            write_active((phases_run % 5) != 4);
            no_idle = (phases_run % 4) == 1;
            if (phases_run == 3) hold_rsp_req = 1'b1;
            case (kind)
                PH_FILL:  insert_pct = 85;
                PH_DRAIN: insert_pct = 20;
                default:  insert_pct = 50;
            endcase
            phase_len = $urandom_range(120, 220);
            repeat (phase_len) begin
                if ($urandom_range(0, 99) < insert_pct) begin
                    push_job(pick_key(), TAG_W'($urandom));
                end else begin
                    pop_min();
                end
            end
            phases_run++;
        end
        write_active(1'b1);

        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_cnt != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("run covered %0d request beats in %0d random phases", beats_sent, phases_run);
        $display("fill past full, drain past empty, %0d queue_active writes, one long stall",
                 cfg_writes);
        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* binary_min_heap_queue_top.f */
sv/hmq_pkg.sv
sv/hmq_in_if.sv
sv/hmq_out_if.sv
sv/hmq_cell.sv
sv/binary_min_heap_queue_top.sv
tb/binary_min_heap_queue_checker.sv
tb/binary_min_heap_queue_top_tb.sv
